// ----- hw/rtl/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and codes for the LRU block cache tag controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int FILE_W = 8;
	localparam int BLK_W  = 24;
	localparam int TAG_W  = FILE_W + BLK_W;
	localparam int KIND_W = 3;
	localparam int STAT_W = 3;

	typedef enum logic [KIND_W-1:0] {
		K_READ  = 3'd0,
		K_WRITE = 3'd1,
		K_PIN   = 3'd2,
		K_UNPIN = 3'd3,
		K_FLUSH = 3'd4,
		K_CLEAR = 3'd5
	} kind_t;

	localparam logic [STAT_W-1:0] ST_HIT     = 3'd0;
	localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
	localparam logic [STAT_W-1:0] ST_PINNED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
	localparam logic [STAT_W-1:0] ST_FLUSHED = 3'd4;
	localparam logic [STAT_W-1:0] ST_DONE    = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	// strobes from the sequencer to the datapath
	typedef struct packed {
		logic adv;
		logic rd_en;
		logic accept;
		logic fin;
	} ctl_t;

endpackage

// ----- hw/rtl/lbc_tag_mem.sv -----
// ----------------------------------------------------------------------------
// lbc_tag_mem
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbc_tag_mem #(
	parameter int DEPTH = 16,
	parameter int W     = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hw/rtl/lru_block_cache_with_pinning.sv -----
// ----------------------------------------------------------------------------
// lru_block_cache_with_pinning
// Tag and LRU policy controller of a block cache with pinning and dirty
// write-back. Tags live in a synchronous memory; valid, dirty, pin and age
// bits sit in flops.
//
//  channel | signals                                        | dir
//  req     | req_valid req_stall kind file_id block_index   | in
//  rsp     | rsp_valid rsp_stall status slot fetch writeback | out
//          | wb_file_id wb_block_index last                 |
//
// Read, write, pin, unpin and flush scan all ENTRIES tags through the memory
// read port, one per cycle unless a flush stalls the scan; clear and unknown
// kinds skip the scan. Flush emits one transaction per dirty entry during the
// scan and stalls the scan while the response register is held.
// Reset is asynchronous; it empties the cache. No request is taken until the
// previous command has delivered its final response into the output register.
// ----------------------------------------------------------------------------
module lru_block_cache_with_pinning #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [lbc_pkg::KIND_W-1:0]    kind,
	input  logic [lbc_pkg::FILE_W-1:0]    file_id,
	input  logic [lbc_pkg::BLK_W-1:0]     block_index,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [lbc_pkg::STAT_W-1:0]    status,
	output logic [$clog2(ENTRIES)-1:0]    slot,
	output logic                          fetch,
	output logic                          writeback,
	output logic [lbc_pkg::FILE_W-1:0]    wb_file_id,
	output logic [lbc_pkg::BLK_W-1:0]     wb_block_index,
	output logic                          last
);
	import lbc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] N_ENT = CW'(ENTRIES);

	state_t state_q, state_d;
	ctl_t   ctl;

	logic [ENTRIES-1:0] valid_q, dirty_q, pin_q;
	logic [IW-1:0]      age_q [ENTRIES];
	logic [CW-1:0]      used_q;

	logic [KIND_W-1:0]  kind_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CW-1:0]      cnt_q;
	logic               vld_s1;
	logic [IW-1:0]      idx_s1;
	logic               hit_q, free_fnd_q, vic_fnd_q, any_q;
	logic [IW-1:0]      hit_idx_q, free_idx_q, vic_idx_q;
	logic [TAG_W-1:0]   vic_tag_q;

	logic [TAG_W-1:0]   rdata;
	logic               out_vld_q, out_free, out_load;
	logic               is_flush, emit_now, scan_done;
	logic [ENTRIES-1:0] above_mask;

	// final-result decode
	logic [STAT_W-1:0]  f_status;
	logic [IW-1:0]      f_slot;
	logic               f_fetch, f_wb, f_install, f_promote;
	logic [TAG_W-1:0]   f_wtag;
	logic [IW-1:0]      f_limit;
	logic               f_nolimit;

	assign is_flush  = (kind_q == K_FLUSH);
	assign emit_now  = vld_s1 && valid_q[idx_s1] && dirty_q[idx_s1];
	assign out_free  = !out_vld_q || !rsp_stall;
	assign scan_done = (cnt_q == N_ENT) && !vld_s1;

	// dirty entries strictly above the one being flushed
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			above_mask[i] = (i > int'(idx_s1)) && valid_q[i] && dirty_q[i];
		end
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = (kind == K_CLEAR || kind > K_FLUSH) ? S_FIN : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = (is_flush && any_q) ? S_IDLE : S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: ctl.accept = req_valid;
			S_SCAN: begin
				ctl.adv   = !(is_flush && emit_now && !out_free);
				ctl.rd_en = ctl.adv && (cnt_q < N_ENT);
			end
			S_FIN:  ctl.fin = out_free;
			default: ctl = '0;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	// ---------------- tag memory ----------------
	lbc_tag_mem #(.DEPTH(ENTRIES), .W(TAG_W)) u_mem (
		.clk   (clk),
		.we    (ctl.fin && f_install),
		.waddr (f_slot),
		.wdata (tag_q),
		.re    (ctl.rd_en),
		.raddr (cnt_q[IW-1:0]),
		.rdata (rdata)
	);

	// ---------------- final result ----------------
	always_comb begin
		f_status  = ST_DONE;
		f_slot    = '0;
		f_fetch   = 1'b0;
		f_wb      = 1'b0;
		f_install = 1'b0;
		f_promote = 1'b0;
		f_wtag    = '0;
		f_limit   = '0;
		f_nolimit = 1'b0;
		case (kind_q) inside
			K_READ, K_WRITE: begin
				if (hit_q) begin
					f_status  = ST_HIT;
					f_slot    = hit_idx_q;
					f_promote = (kind_q == K_READ);
					f_limit   = age_q[hit_idx_q];
				end else if (used_q < N_ENT && free_fnd_q) begin
					f_status  = ST_MISS;
					f_slot    = free_idx_q;
					f_fetch   = 1'b1;
					f_install = 1'b1;
					f_promote = 1'b1;
					f_nolimit = 1'b1;
				end else if (used_q >= N_ENT && vic_fnd_q) begin
					f_status  = ST_MISS;
					f_slot    = vic_idx_q;
					f_fetch   = 1'b1;
					f_install = 1'b1;
					f_promote = 1'b1;
					f_limit   = age_q[vic_idx_q];
					f_wb      = dirty_q[vic_idx_q];
					f_wtag    = dirty_q[vic_idx_q] ? vic_tag_q : '0;
				end else begin
					f_status = ST_PINNED;
				end
			end
			K_PIN, K_UNPIN: begin
				if (hit_q) begin
					f_status = ST_HIT;
					f_slot   = hit_idx_q;
				end else begin
					f_status = ST_ABSENT;
				end
			end
			default: f_status = ST_DONE;
		endcase
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			dirty_q    <= '0;
			pin_q      <= '0;
			used_q     <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			hit_q      <= 1'b0;
			free_fnd_q <= 1'b0;
			vic_fnd_q  <= 1'b0;
			any_q      <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (ctl.accept) begin
				cnt_q      <= '0;
				vld_s1     <= 1'b0;
				hit_q      <= 1'b0;
				free_fnd_q <= 1'b0;
				vic_fnd_q  <= 1'b0;
				any_q      <= 1'b0;
			end
			if (ctl.adv) begin
				vld_s1 <= (cnt_q < N_ENT);
				if (cnt_q < N_ENT) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (vld_s1) begin
					if (valid_q[idx_s1] && rdata == tag_q) begin
						hit_q <= 1'b1;
					end
					if (!valid_q[idx_s1] && !free_fnd_q) begin
						free_fnd_q <= 1'b1;
					end
					if (valid_q[idx_s1] && !pin_q[idx_s1] &&
						(!vic_fnd_q || age_q[idx_s1] > age_q[vic_idx_q])) begin
						vic_fnd_q <= 1'b1;
					end
					if (is_flush && emit_now) begin
						dirty_q[idx_s1] <= 1'b0;
						any_q           <= 1'b1;
					end
				end
			end
			if (ctl.fin) begin
				if (kind_q == K_CLEAR) begin
					valid_q <= '0;
					dirty_q <= '0;
					pin_q   <= '0;
					used_q  <= '0;
					for (int i = 0; i < ENTRIES; i++) begin
						age_q[i] <= '0;
					end
				end
				if ((kind_q == K_PIN || kind_q == K_UNPIN) && hit_q) begin
					pin_q[hit_idx_q] <= (kind_q == K_PIN);
				end
				if (kind_q == K_WRITE && hit_q) begin
					dirty_q[hit_idx_q] <= 1'b1;
				end
				if (f_install) begin
					valid_q[f_slot] <= 1'b1;
					dirty_q[f_slot] <= (kind_q == K_WRITE);
					pin_q[f_slot]   <= 1'b0;
					if (f_nolimit) begin
						used_q <= used_q + 1'b1;
					end
				end
				if (f_promote) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_q[i] && i != int'(f_slot) &&
							(f_nolimit || age_q[i] < f_limit)) begin
							age_q[i] <= age_q[i] + 1'b1;
						end
					end
					age_q[f_slot] <= '0;
				end
			end
		end
	end

	// scan payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			kind_q <= kind;
			tag_q  <= {file_id, block_index};
		end
		if (ctl.adv) begin
			idx_s1 <= cnt_q[IW-1:0];
			if (vld_s1) begin
				if (valid_q[idx_s1] && rdata == tag_q) begin
					hit_idx_q <= idx_s1;
				end
				if (!valid_q[idx_s1] && !free_fnd_q) begin
					free_idx_q <= idx_s1;
				end
				if (valid_q[idx_s1] && !pin_q[idx_s1] &&
					(!vic_fnd_q || age_q[idx_s1] > age_q[vic_idx_q])) begin
					vic_idx_q <= idx_s1;
					vic_tag_q <= rdata;
				end
			end
		end
	end

	// ---------------- response register ----------------
	assign out_load = ctl.fin || (state_q == S_SCAN && ctl.adv && is_flush && emit_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ctl.fin) begin
				status         <= f_status;
				slot           <= f_slot;
				fetch          <= f_fetch;
				writeback      <= f_wb;
				wb_file_id     <= f_wtag[TAG_W-1:BLK_W];
				wb_block_index <= f_wtag[BLK_W-1:0];
				last           <= 1'b1;
			end else begin
				status         <= ST_FLUSHED;
				slot           <= idx_s1;
				fetch          <= 1'b0;
				writeback      <= 1'b1;
				wb_file_id     <= rdata[TAG_W-1:BLK_W];
				wb_block_index <= rdata[BLK_W-1:0];
				last           <= (above_mask == '0);
			end
		end
	end

	assign rsp_valid = out_vld_q;

	// ---------------- assertions ----------------
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) == $countones(valid_q))
		else $error("used count out of step with valid bits");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("response register overwritten while held");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= N_ENT)
		else $error("scan counter past last entry");

	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != S_IDLE))
		else $error("accepted transaction left no work");
endmodule
